>>> rtl/atg_pkg.sv
// Shared types, constants and helper functions of the axis tick generator.
package atg_pkg;

  localparam int VW = 32;
  localparam int SW = 34;
  localparam int XW = 37;
  localparam int WW = 40;
  localparam int MW = 45;
  localparam int IW = 3;
  localparam int EW = 4;
  localparam int CW = 5;

  localparam logic [IW-1:0] LAST_SLOT = 3'd7;
  localparam logic [SW-1:0] BASE_CAP  = 34'd1000000000;

  typedef struct packed {
    logic signed [VW-1:0] mn;
    logic signed [VW-1:0] mx;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic [SW-1:0]        step;
    logic signed [XW-1:0] x0;
    logic signed [EW-1:0] lex;
    logic                 eq;
  } job_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [IW-1:0]        index;
    logic                 last;
    logic [SW-1:0]        step;
    logic signed [EW-1:0] lex;
  } word_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_PREP,
    F_LEX,
    F_SEARCH,
    F_PICK,
    F_DSTART,
    F_DWAIT,
    F_FIX,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FIRST,
    B_WALK,
    B_LAST
  } back_state_t;

  function automatic logic [VW-1:0] pow10(input logic [3:0] k);
    logic [VW-1:0] p;
    case (k)
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  // The magnitude is compared against all powers of ten at once; the count
  // of those not above it is the decimal logarithm.
  function automatic logic signed [EW-1:0] legend_exp(input logic [VW-1:0] m);
    logic [3:0]           lg;
    logic signed [EW-1:0] e;
    lg = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (m >= pow10(4'(k))) begin
        lg = lg + 4'd1;
      end
    end
    if (m == '0) begin
      e = 4'sd0;
    end else begin
      case (lg)
        4'd0:       e = -4'sd3;
        4'd7, 4'd8: e = 4'sd3;
        4'd9:       e = 4'sd6;
        default:    e = 4'sd0;
      endcase
    end
    return e;
  endfunction

endpackage

>>> rtl/axis_tick_generator_core.sv
// Axis tick generator top level: front end, request queue and tick walker.
//
// Each request (axis_min, axis_max in thousandths) yields one to eight words:
// axis_min first, then the multiples of a nice step (1, 2 or 5 times a power
// of ten, near a quarter of the span) lying inside the range and at least
// 0.67 step from both ends, then axis_max flagged as last; equal ends give a
// single word with a step of zero. Every word also carries the step and a
// legend exponent that is a multiple of three. The front end takes no new
// request until it has handed the last one over; in between it runs a
// power-of-ten search, waits on the 32-step bit-serial remainder unit that
// finds the first grid point and does setup and handover, while a request
// with equal ends skips the search and the remainder unit. It stalls while
// the queue is full. The back end takes a request from the queue, hands out
// the first word, walks the grid, where each point is handed out or skipped,
// leaves the walk and hands out the last word; it stalls while its output
// register holds a word that is not taken. A two-entry queue sits between them,
// so a new request is taken while the ticks of earlier ones are still going out.
module axis_tick_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [atg_pkg::VW-1:0] in_axis_min,
  input  logic signed [atg_pkg::VW-1:0] in_axis_max,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [atg_pkg::VW-1:0] out_tick_value,
  output logic [atg_pkg::IW-1:0]        out_tick_index,
  output logic                          out_is_last,
  output logic [atg_pkg::SW-1:0]        out_step_value,
  output logic signed [atg_pkg::EW-1:0] out_legend_exponent
);

  atg_pkg::job_t  fq_job, qb_job;
  atg_pkg::word_t word;
  logic           fq_push, fq_full;
  logic           qb_pop, qb_empty;

  atg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .axis_min (in_axis_min),
    .axis_max (in_axis_max),
    .q_push   (fq_push),
    .q_job    (fq_job),
    .q_full   (fq_full)
  );

  atg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fq_push),
    .wr_job (fq_job),
    .full   (fq_full),
    .rd_en  (qb_pop),
    .rd_job (qb_job),
    .empty  (qb_empty)
  );

  atg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (qb_empty),
    .q_job   (qb_job),
    .q_pop   (qb_pop),
    .empty   (empty),
    .pop     (pop),
    .word    (word)
  );

  assign out_tick_value      = word.value;
  assign out_tick_index      = word.index;
  assign out_is_last         = word.last;
  assign out_step_value      = word.step;
  assign out_legend_exponent = word.lex;

endmodule

>>> rtl/atg_div.sv
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
module atg_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [atg_pkg::VW-1:0] dividend,
  input  logic [atg_pkg::SW-1:0] divisor,
  output logic                   done,
  output logic [atg_pkg::SW-1:0] rem
);

  logic                   busy_r;
  logic                   done_r;
  logic [atg_pkg::CW-1:0] cnt_r;
  logic [atg_pkg::VW-1:0] dvd_r;
  logic [atg_pkg::SW-1:0] dsr_r;
  logic [atg_pkg::SW-1:0] acc_r;
  logic [atg_pkg::SW:0]   trial;
  logic [atg_pkg::SW-1:0] acc_nxt;

  always_comb begin
    trial = {acc_r, dvd_r[atg_pkg::VW-1]};
    if (trial >= {1'b0, dsr_r}) begin
      acc_nxt = atg_pkg::SW'(trial - {1'b0, dsr_r});
    end else begin
      acc_nxt = trial[atg_pkg::SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      acc_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[atg_pkg::VW-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign rem  = acc_r;

endmodule

>>> rtl/atg_front.sv
// Front end: accepts an axis request and works out step, legend and first grid tick.
module atg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [atg_pkg::VW-1:0] axis_min,
  input  logic signed [atg_pkg::VW-1:0] axis_max,
  output logic                          q_push,
  output atg_pkg::job_t                 q_job,
  input  logic                          q_full
);

  atg_pkg::front_state_t state_r, state_nxt;

  logic signed [atg_pkg::VW-1:0] mn_r, mx_r, lo_r, hi_r;
  logic [atg_pkg::VW-1:0]        r_r;
  logic [atg_pkg::VW-1:0]        m_r;
  logic                          eq_r;
  logic signed [atg_pkg::EW-1:0] lex_r;
  logic [atg_pkg::SW-1:0]        base_r;
  logic [atg_pkg::SW-1:0]        step_r;
  logic signed [atg_pkg::XW-1:0] x0_r;

  logic [atg_pkg::VW:0]   mn33, mx33, diff33, span33, amn33, amx33, alo33;
  logic [atg_pkg::WW-1:0] b40, r40, b40x40, b40x6, b40x12, b40x28;
  logic                   grow;
  logic [atg_pkg::SW-1:0] pick;
  logic                   div_start, div_done;
  logic [atg_pkg::SW-1:0] div_rem, fr;
  logic [atg_pkg::XW-1:0] x0_calc;

  always_comb begin
    mn33   = {mn_r[atg_pkg::VW-1], mn_r};
    mx33   = {mx_r[atg_pkg::VW-1], mx_r};
    diff33 = mx33 - mn33;
    span33 = diff33[atg_pkg::VW] ? (33'd0 - diff33) : diff33;
    amn33  = mn33[atg_pkg::VW] ? (33'd0 - mn33) : mn33;
    amx33  = mx33[atg_pkg::VW] ? (33'd0 - mx33) : mx33;
    alo33  = {lo_r[atg_pkg::VW-1], lo_r};
    if (alo33[atg_pkg::VW]) begin
      alo33 = 33'd0 - alo33;
    end
  end

  always_comb begin
    b40    = {{(atg_pkg::WW-atg_pkg::SW){1'b0}}, base_r};
    r40    = {{(atg_pkg::WW-atg_pkg::VW){1'b0}}, r_r};
    b40x40 = (b40 << 5) + (b40 << 3);
    b40x6  = (b40 << 2) + (b40 << 1);
    b40x12 = b40x6 << 1;
    b40x28 = (b40 << 5) - (b40 << 2);
    grow   = (base_r <= atg_pkg::BASE_CAP) && (b40x40 <= r40);
    if (r40 < b40x6) begin
      pick = base_r;
    end else if (r40 < b40x12) begin
      pick = base_r << 1;
    end else if (r40 < b40x28) begin
      pick = (base_r << 2) + base_r;
    end else begin
      pick = (base_r << 3) + (base_r << 1);
    end
  end

  // Floor remainder of the lower end: a negative value with a nonzero
  // magnitude remainder is pulled down to the next multiple below.
  always_comb begin
    if (lo_r[atg_pkg::VW-1]) begin
      fr = (div_rem == '0) ? '0 : (step_r - div_rem);
    end else begin
      fr = div_rem;
    end
    x0_calc = {{(atg_pkg::XW-atg_pkg::VW){lo_r[atg_pkg::VW-1]}}, lo_r}
            - {{(atg_pkg::XW-atg_pkg::SW){1'b0}}, fr}
            + {{(atg_pkg::XW-atg_pkg::SW){1'b0}}, step_r};
  end

  atg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (alo33[atg_pkg::VW-1:0]),
    .divisor  (step_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    full      = 1'b1;
    q_push    = 1'b0;
    div_start = 1'b0;
    case (state_r)
      atg_pkg::F_IDLE: begin
        full = 1'b0;
        if (push) begin
          state_nxt = atg_pkg::F_PREP;
        end
      end
      atg_pkg::F_PREP: begin
        state_nxt = atg_pkg::F_LEX;
      end
      atg_pkg::F_LEX: begin
        state_nxt = eq_r ? atg_pkg::F_PUSH : atg_pkg::F_SEARCH;
      end
      atg_pkg::F_SEARCH: begin
        if (!grow) begin
          state_nxt = atg_pkg::F_PICK;
        end
      end
      atg_pkg::F_PICK: begin
        state_nxt = atg_pkg::F_DSTART;
      end
      atg_pkg::F_DSTART: begin
        div_start = 1'b1;
        state_nxt = atg_pkg::F_DWAIT;
      end
      atg_pkg::F_DWAIT: begin
        if (div_done) begin
          state_nxt = atg_pkg::F_FIX;
        end
      end
      atg_pkg::F_FIX: begin
        state_nxt = atg_pkg::F_PUSH;
      end
      atg_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = atg_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = atg_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      atg_pkg::F_IDLE: begin
        if (push) begin
          mn_r <= axis_min;
          mx_r <= axis_max;
        end
      end
      atg_pkg::F_PREP: begin
        lo_r   <= (mn_r < mx_r) ? mn_r : mx_r;
        hi_r   <= (mn_r < mx_r) ? mx_r : mn_r;
        r_r    <= span33[atg_pkg::VW-1:0];
        m_r    <= (amn33 > amx33) ? amn33[atg_pkg::VW-1:0] : amx33[atg_pkg::VW-1:0];
        eq_r   <= (mn_r == mx_r);
        base_r <= atg_pkg::SW'(1);
      end
      atg_pkg::F_LEX: begin
        lex_r <= atg_pkg::legend_exp(m_r);
      end
      atg_pkg::F_SEARCH: begin
        if (grow) begin
          base_r <= (base_r << 3) + (base_r << 1);
        end
      end
      atg_pkg::F_PICK: begin
        step_r <= pick;
      end
      atg_pkg::F_FIX: begin
        x0_r <= x0_calc;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q_job.mn   = mn_r;
    q_job.mx   = mx_r;
    q_job.lo   = lo_r;
    q_job.hi   = hi_r;
    q_job.step = eq_r ? '0 : step_r;
    q_job.x0   = x0_r;
    q_job.lex  = lex_r;
    q_job.eq   = eq_r;
  end

endmodule

>>> rtl/atg_queue.sv
// Two-entry queue of prepared requests between the front and back ends.
module atg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  atg_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output atg_pkg::job_t rd_job,
  output logic          empty
);

  atg_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

>>> rtl/atg_back.sv
// Back end: walks the grid of one request and hands out ticks through an output register.
module atg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  atg_pkg::job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output atg_pkg::word_t word
);

  atg_pkg::back_state_t state_r, state_nxt;

  atg_pkg::job_t                 job_r, job_nxt;
  logic signed [atg_pkg::XW-1:0] x_r, x_nxt;
  logic [atg_pkg::IW-1:0]        n_r, n_nxt;
  atg_pkg::word_t                word_r, word_nxt;
  logic                          valid_r;
  logic                          load;
  logic                          can_load;

  logic signed [atg_pkg::XW-1:0] lo_x, hi_x;
  logic signed [atg_pkg::MW-1:0] dl, dh, d45, dl100, dh100, lim;
  logic                          inrun, skip;

  assign can_load = !valid_r || pop;
  assign empty    = !valid_r;
  assign word     = word_r;

  // A grid point closer than 0.67 step to either end is dropped; the test
  // is done as 100 * distance against 67 * step.
  always_comb begin
    lo_x  = {{(atg_pkg::XW-atg_pkg::VW){job_r.lo[atg_pkg::VW-1]}}, job_r.lo};
    hi_x  = {{(atg_pkg::XW-atg_pkg::VW){job_r.hi[atg_pkg::VW-1]}}, job_r.hi};
    dl    = atg_pkg::MW'(x_r - lo_x);
    dh    = atg_pkg::MW'(hi_x - x_r);
    d45   = $signed({{(atg_pkg::MW-atg_pkg::SW){1'b0}}, job_r.step});
    dl100 = (dl <<< 6) + (dl <<< 5) + (dl <<< 2);
    dh100 = (dh <<< 6) + (dh <<< 5) + (dh <<< 2);
    lim   = (d45 <<< 6) + (d45 <<< 1) + d45;
    inrun = (x_r < hi_x) && (n_r != atg_pkg::LAST_SLOT);
    skip  = (dl100 < lim) || (dh100 < lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atg_pkg::B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    x_r   <= x_nxt;
    n_r   <= n_nxt;
    if (load) begin
      word_r <= word_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    x_nxt          = x_r;
    n_nxt          = n_r;
    q_pop          = 1'b0;
    load           = 1'b0;
    word_nxt.value = job_r.mn;
    word_nxt.index = n_r;
    word_nxt.last  = 1'b0;
    word_nxt.step  = job_r.step;
    word_nxt.lex   = job_r.lex;
    case (state_r)
      atg_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          x_nxt     = q_job.x0;
          n_nxt     = '0;
          state_nxt = atg_pkg::B_FIRST;
        end
      end
      atg_pkg::B_FIRST: begin
        word_nxt.index = '0;
        word_nxt.last  = job_r.eq;
        if (can_load) begin
          load      = 1'b1;
          n_nxt     = atg_pkg::IW'(1);
          state_nxt = job_r.eq ? atg_pkg::B_IDLE : atg_pkg::B_WALK;
        end
      end
      atg_pkg::B_WALK: begin
        word_nxt.value = x_r[atg_pkg::VW-1:0];
        if (!inrun) begin
          state_nxt = atg_pkg::B_LAST;
        end else if (skip) begin
          x_nxt = x_r + {{(atg_pkg::XW-atg_pkg::SW){1'b0}}, job_r.step};
        end else if (can_load) begin
          load  = 1'b1;
          n_nxt = n_r + 1'b1;
          x_nxt = x_r + {{(atg_pkg::XW-atg_pkg::SW){1'b0}}, job_r.step};
        end
      end
      atg_pkg::B_LAST: begin
        word_nxt.value = job_r.mx;
        word_nxt.last  = 1'b1;
        if (can_load) begin
          load      = 1'b1;
          state_nxt = atg_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = atg_pkg::B_IDLE;
      end
    endcase
  end

endmodule
